FILE: hdl/cpbc_pkg.sv
// Shared types, constants and register codes for the capture period beacon classifier.
package cpbc_pkg;

  localparam int unsigned CAP_W     = 16;
  localparam int unsigned ROLL_W    = 16;
  localparam int unsigned TIME_W    = ROLL_W + CAP_W;
  localparam int unsigned RATE_W    = 25;
  localparam int unsigned TOL_W     = 8;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned NUM_BEACONS = 4;
  localparam int unsigned BEACON_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = RATE_W;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CAP_W-1:0] HALF_RANGE = 16'h8000;

  localparam logic [RATE_W-1:0] TICK_RATE_RST = 25'd2500000;
  localparam logic [TOL_W-1:0]  TOLERANCE_RST = 8'd30;
  localparam logic [FREQ_W-1:0] FREQ_G_RST    = 16'd3333;
  localparam logic [FREQ_W-1:0] FREQ_B_RST    = 16'd1427;
  localparam logic [FREQ_W-1:0] FREQ_R_RST    = 16'd909;
  localparam logic [FREQ_W-1:0] FREQ_L_RST    = 16'd2000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_G    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_R    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_L    = 3'd5;

  // Beacon codes, also their place in the priority order.
  localparam logic [BEACON_W-1:0] BCN_G = 2'd0;
  localparam logic [BEACON_W-1:0] BCN_B = 2'd1;
  localparam logic [BEACON_W-1:0] BCN_R = 2'd2;
  localparam logic [BEACON_W-1:0] BCN_L = 2'd3;

  // Input action codes.
  localparam logic ACT_CAPTURE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef logic [NUM_BEACONS-1:0][FREQ_W-1:0] beacon_freqs_t;

  typedef struct packed {
    logic              action;
    logic [CAP_W-1:0]  capture_time;
    logic              overflow_pending;
  } in_word_t;

  typedef struct packed {
    logic                detected;
    logic [BEACON_W-1:0] beacon;
    logic [RATE_W-1:0]   frequency;
    logic [TIME_W-1:0]   period;
  } out_word_t;

  typedef struct packed {
    logic                done;
    logic                detected;
    logic [BEACON_W-1:0] beacon;
  } match_stat_t;

endpackage

FILE: hdl/cpbc_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module cpbc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cpbc_pkg::RATE_W-1:0]   dividend,
  input  logic [cpbc_pkg::TIME_W-1:0]   divisor,
  output logic                          done,
  output logic [cpbc_pkg::RATE_W-1:0]   quotient
);
  import cpbc_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(RATE_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    dvsr;
  logic [TIME_W:0]      shifted;
  logic [TIME_W:0]      diff;
  logic                 fits;

  assign shifted = {rem, quotient[RATE_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = (shifted >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvsr     <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // The dividend shifts out at the top while quotient bits shift in below.
      rem      <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      quotient <= {quotient[RATE_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/cpbc_match.sv
// Beacon matcher: one shared distance compare walks the beacons in priority order.
module cpbc_match (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cpbc_pkg::RATE_W-1:0]   frequency,
  input  logic [cpbc_pkg::TOL_W-1:0]    tolerance,
  input  cpbc_pkg::beacon_freqs_t       nominal,
  output cpbc_pkg::match_stat_t         stat
);
  import cpbc_pkg::*;

  logic                busy;
  logic [BEACON_W-1:0] idx;
  logic [RATE_W-1:0]   nom;
  logic [RATE_W-1:0]   delta;
  logic                hit;

  assign nom   = RATE_W'(nominal[idx]);
  assign delta = (frequency >= nom) ? (frequency - nom) : (nom - frequency);
  assign hit   = (delta <= RATE_W'(tolerance));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      idx           <= '0;
      stat.done     <= 1'b0;
      stat.detected <= 1'b0;
      stat.beacon   <= BCN_G;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= BCN_G;
      end else if (busy) begin
        if (hit) begin
          busy          <= 1'b0;
          stat.done     <= 1'b1;
          stat.detected <= 1'b1;
          stat.beacon   <= idx;
        end else if (idx == BCN_L) begin
          // No beacon within tolerance: report beacon G with no detection.
          busy          <= 1'b0;
          stat.done     <= 1'b1;
          stat.detected <= 1'b0;
          stat.beacon   <= BCN_G;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/capture_period_beacon_classifier_core.sv
// Top level: capture timestamping, sequencer, configuration registers and output word register.
// Flow: a tick or a zero-period capture goes from idle straight to the done state; other
// captures first run 25 divider steps and then 1 to 4 matcher steps before the done state.
// A new word is accepted only in the idle state, once the last one has left the done state.
// A finished word waits in the output register while the next word is accepted.
// Synchronous reset restores register defaults and clears rollover count and previous time.
module capture_period_beacon_classifier_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cpbc_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cpbc_pkg::out_word_t              out_word,
  input  logic                             cfg_we,
  input  logic [cpbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cpbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_MATCH = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  logic [RATE_W-1:0] tick_rate;
  logic [TOL_W-1:0]  tolerance;
  beacon_freqs_t     nominal;

  logic [ROLL_W-1:0] rollover_count;
  logic [TIME_W-1:0] previous_time;

  logic [ROLL_W-1:0] rollover_next;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] period_next;
  logic              accept;
  logic              is_capture;
  logic              out_load;

  out_word_t         result;

  logic              div_start;
  logic              div_done;
  logic [RATE_W-1:0] quotient;
  logic              match_start;
  match_stat_t       mstat;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_capture = (in_word.action == ACT_CAPTURE);
  assign out_load   = (state == ST_DONE) && (!out_valid || !out_stall);

  // A pending overflow with a low capture value means the rollover belongs to this capture.
  always_comb begin
    rollover_next = rollover_count;
    if (!is_capture || (in_word.overflow_pending && (in_word.capture_time < HALF_RANGE))) begin
      rollover_next = rollover_count + 1'b1;
    end
  end

  assign now         = {rollover_next, in_word.capture_time};
  assign period_next = now - previous_time;
  assign div_start   = accept && is_capture && (period_next != '0);
  assign match_start = (state == ST_DIV) && div_done;

  cpbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tick_rate),
    .divisor  (period_next),
    .done     (div_done),
    .quotient (quotient)
  );

  cpbc_match u_match (
    .clk       (clk),
    .rst       (rst),
    .start     (match_start),
    .frequency (quotient),
    .tolerance (tolerance),
    .nominal   (nominal),
    .stat      (mstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate  <= TICK_RATE_RST;
      tolerance  <= TOLERANCE_RST;
      nominal[0] <= FREQ_G_RST;
      nominal[1] <= FREQ_B_RST;
      nominal[2] <= FREQ_R_RST;
      nominal[3] <= FREQ_L_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RATE: tick_rate  <= cfg_data;
        CFG_TOLERANCE: tolerance  <= cfg_data[TOL_W-1:0];
        CFG_FREQ_G:    nominal[0] <= cfg_data[FREQ_W-1:0];
        CFG_FREQ_B:    nominal[1] <= cfg_data[FREQ_W-1:0];
        CFG_FREQ_R:    nominal[2] <= cfg_data[FREQ_W-1:0];
        CFG_FREQ_L:    nominal[3] <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rollover_count <= '0;
      previous_time  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rollover_count <= rollover_next;
            if (is_capture) begin
              previous_time <= now;
            end
            state <= div_start ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (mstat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result word assembly; ticks and zero periods leave everything but the period at zero.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          result.detected  <= 1'b0;
          result.beacon    <= BCN_G;
          result.frequency <= '0;
          result.period    <= is_capture ? period_next : '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          result.frequency <= quotient;
        end
      end
      ST_MATCH: begin
        if (mstat.done) begin
          result.detected <= mstat.detected;
          result.beacon   <= mstat.beacon;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_word <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/capture_period_beacon_classifier_core_test.sv
// Self-checking testbench for the capture period beacon classifier with its own predictor.
module capture_period_beacon_classifier_core_test;
  import cpbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PROBE_ROWS = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    in_word_t  stim;
    logic      typed;
    out_word_t want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the timestamp state.
  logic [RATE_W-1:0] rate_reg;
  logic [TOL_W-1:0] tol_reg;
  logic [FREQ_W-1:0] beacon_hz [NUM_BEACONS];
  logic [ROLL_W-1:0] roll_cnt;
  logic [TIME_W-1:0] last_stamp;

  out_word_t awaited_readings [$];
  int words_accepted = 0;
  int readings_checked = 0;
  int mismatches = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  // Directed words: typed-in results only where they follow at a glance from reset values.
  probe_row_t probe_rows [PROBE_ROWS] = '{
    {ACT_TICK,    16'h0000, 1'b0, 1'b1, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'h0000, 1'b0, 1'b1, 1'b0, BCN_G, 25'd38,      32'd65536},
    {ACT_CAPTURE, 16'h0000, 1'b0, 1'b1, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'd750,  1'b0, 1'b1, 1'b1, BCN_G, 25'd3333,    32'd750},
    {ACT_CAPTURE, 16'd2502, 1'b0, 1'b1, 1'b1, BCN_B, 25'd1426,    32'd1752},
    {ACT_CAPTURE, 16'd5252, 1'b0, 1'b1, 1'b1, BCN_R, 25'd909,     32'd2750},
    {ACT_CAPTURE, 16'd6502, 1'b0, 1'b1, 1'b1, BCN_L, 25'd2000,    32'd1250},
    {ACT_CAPTURE, 16'h7FFF, 1'b1, 1'b0, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'h8000, 1'b1, 1'b1, 1'b0, BCN_G, 25'd2500000, 32'd1},
    {ACT_CAPTURE, 16'hFFFF, 1'b0, 1'b0, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'h0000, 1'b1, 1'b1, 1'b0, BCN_G, 25'd2500000, 32'd1},
    {ACT_CAPTURE, 16'h8000, 1'b0, 1'b0, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'h0001, 1'b0, 1'b1, 1'b0, BCN_G, 25'd0,       32'hFFFF8001},
    {ACT_TICK,    16'hFFFF, 1'b1, 1'b1, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_TICK,    16'h0000, 1'b0, 1'b1, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'h5555, 1'b1, 1'b0, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'hAAAA, 1'b0, 1'b0, 1'b0, BCN_G, 25'd0,       32'd0},
    {ACT_CAPTURE, 16'hAAAA, 1'b1, 1'b1, 1'b0, BCN_G, 25'd0,       32'd0}
  };

  capture_period_beacon_classifier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advances the timestamp state by one word and returns the reading it produces.
  function automatic out_word_t classify_word(in_word_t w);
    out_word_t res;
    logic [TIME_W-1:0] stamp;
    logic [31:0] quo;
    logic [31:0] delta;
    res = '0;
    if (w.action == ACT_TICK) begin
      roll_cnt = roll_cnt + 1'b1;
    end else begin
      if (w.overflow_pending && w.capture_time < HALF_RANGE) roll_cnt = roll_cnt + 1'b1;
      stamp = {roll_cnt, w.capture_time};
      res.period = stamp - last_stamp;
      if (res.period != 0) begin
        quo = {7'd0, rate_reg} / res.period;
        res.frequency = quo[RATE_W-1:0];
        // Beacon codes match the priority order, so the first hit wins.
        for (int k = 0; k < NUM_BEACONS; k++) begin
          delta = (quo >= beacon_hz[k]) ? quo - beacon_hz[k] : beacon_hz[k] - quo;
          if (!res.detected && delta <= tol_reg) begin
            res.detected = 1'b1;
            res.beacon = BEACON_W'(k);
          end
        end
      end
      last_stamp = stamp;
    end
    return res;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t res;
    int gap;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = classify_word(w);
    awaited_readings.push_back(typed ? want : res);
    words_accepted++;
    if (idle_on) begin
      gap = gap_len();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    case (idx)
      CFG_TICK_RATE: rate_reg = data[RATE_W-1:0];
      CFG_TOLERANCE: tol_reg = data[TOL_W-1:0];
      CFG_FREQ_G:    beacon_hz[BCN_G] = data[FREQ_W-1:0];
      CFG_FREQ_B:    beacon_hz[BCN_B] = data[FREQ_W-1:0];
      CFG_FREQ_R:    beacon_hz[BCN_R] = data[FREQ_W-1:0];
      CFG_FREQ_L:    beacon_hz[BCN_L] = data[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  // Waits for the block to go idle, then writes every register. Unused upper bits of the
  // narrow registers carry random junk, and the two spare indexes get writes too.
  task automatic apply_settings(input logic [RATE_W-1:0] rate, input logic [TOL_W-1:0] tol,
                                input logic [FREQ_W-1:0] g, input logic [FREQ_W-1:0] b,
                                input logic [FREQ_W-1:0] r, input logic [FREQ_W-1:0] l);
    logic [CFG_DATA_W-1:0] junk;
    in_valid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_TICK_RATE, rate);
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_TOLERANCE, {junk[CFG_DATA_W-1:TOL_W], tol});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FREQ_G, {junk[CFG_DATA_W-1:FREQ_W], g});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FREQ_B, {junk[CFG_DATA_W-1:FREQ_W], b});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FREQ_R, {junk[CFG_DATA_W-1:FREQ_W], r});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_FREQ_L, {junk[CFG_DATA_W-1:FREQ_W], l});
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Most captures land near a beacon period so that tolerance edges get hit; ticks are
  // inserted ahead of them as the timestamp needs. The rest are ticks, repeats and noise.
  task automatic send_random();
    in_word_t w;
    in_word_t tick_w;
    int pick;
    int k;
    int dlt;
    int hzi;
    logic [31:0] span;
    logic [TIME_W-1:0] target;
    logic [ROLL_W-1:0] ahead;
    tick_w = '0;
    tick_w.action = ACT_TICK;
    w = '0;
    w.action = ACT_CAPTURE;
    w.capture_time = CAP_W'($urandom_range(0, 16'hFFFF));
    w.overflow_pending = 1'($urandom_range(0, 1));
    ahead = '0;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w.action = ACT_TICK;
    end else if (pick < 14) begin
      w.capture_time = last_stamp[CAP_W-1:0];
      w.overflow_pending = 1'b0;
    end else if (pick >= 35) begin
      k = $urandom_range(0, NUM_BEACONS - 1);
      dlt = int'($urandom_range(0, 2 * tol_reg + 6)) - int'(tol_reg) - 3;
      hzi = int'(beacon_hz[k]) + dlt;
      if (hzi <= 0 || rate_reg == 0) span = $urandom_range(1, 8);
      else span = {7'd0, rate_reg} / 32'(hzi);
      if (span == 0) span = 1;
      target = last_stamp + span;
      ahead = target[TIME_W-1:CAP_W] - roll_cnt;
      if (ahead <= 16'd40) begin
        w.capture_time = target[CAP_W-1:0];
        if (ahead != 0 && target[CAP_W-1:0] < HALF_RANGE && $urandom_range(0, 1) == 1) begin
          w.overflow_pending = 1'b1;
          ahead = ahead - 1'b1;
        end else begin
          // The flag only counts in the lower half of the timer range.
          w.overflow_pending = (target[CAP_W-1:0] >= HALF_RANGE) ? 1'($urandom_range(0, 1))
                                                                  : 1'b0;
        end
      end else begin
        ahead = '0;
      end
    end
    repeat (ahead) send_word(tick_w, 1'b0, '0);
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = words_accepted + count;
    while (words_accepted < stop_at) begin
      if (words_accepted % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random();
    end
  endtask

  // Receiver side: random stall runs, quiet stretches, and one long hold on request.
  initial begin
    int n;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (1 + $urandom_range(0, 6)) @(posedge clk);
        n = gap_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_readings.size() == 0) begin
        $error("result word arrived with no reading awaited");
        mismatches++;
      end else begin
        want = awaited_readings.pop_front();
        readings_checked++;
        if (out_word.detected !== want.detected) begin
          $error("detected: expected %0d, got %0d", want.detected, out_word.detected);
          mismatches++;
        end
        if (out_word.beacon !== want.beacon) begin
          $error("beacon: expected %0d, got %0d", want.beacon, out_word.beacon);
          mismatches++;
        end
        if (out_word.frequency !== want.frequency) begin
          $error("frequency: expected %0d, got %0d", want.frequency, out_word.frequency);
          mismatches++;
        end
        if (out_word.period !== want.period) begin
          $error("period: expected %0h, got %0h", want.period, out_word.period);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("capture_period_beacon_classifier_core verification failed");
      $finish;
    end
  end

  initial begin
    rate_reg = TICK_RATE_RST;
    tol_reg = TOLERANCE_RST;
    beacon_hz[BCN_G] = FREQ_G_RST;
    beacon_hz[BCN_B] = FREQ_B_RST;
    beacon_hz[BCN_R] = FREQ_R_RST;
    beacon_hz[BCN_L] = FREQ_L_RST;
    roll_cnt = '0;
    last_stamp = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) send_word(probe_rows[i].stim, probe_rows[i].typed,
                                      probe_rows[i].want);
    run_random(250);

    apply_settings(25'd20000000, 8'd255, 16'd65535, 16'd20000, 16'd5000, 16'd0);
    run_random(200);

    // Smallest nonzero tick rate and no tolerance: quotients are 0 or 1.
    apply_settings(25'd1, 8'd0, 16'd0, 16'd1, 16'd2, 16'd65535);
    run_random(150);

    // A zero tick rate still goes through the beacon compare.
    apply_settings(25'd0, 8'd8, 16'd65535, 16'd10, 16'd0, 16'd300);
    run_random(100);

    // Widest values; the receiver holds off while words keep coming.
    apply_settings(25'h1FFFFFF, 8'd255, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
    hold_req = 1'b1;
    run_random(150);

    repeat (3) begin
      apply_settings(RATE_W'($urandom_range(1, 20000000)), TOL_W'($urandom_range(0, 255)),
                     FREQ_W'($urandom_range(200, 5000)), FREQ_W'($urandom_range(200, 5000)),
                     FREQ_W'($urandom_range(200, 5000)), FREQ_W'($urandom_range(200, 5000)));
      run_random(120);
    end

    apply_settings(TICK_RATE_RST, TOLERANCE_RST, FREQ_G_RST, FREQ_B_RST, FREQ_R_RST,
                   FREQ_L_RST);
    run_random(60);

    in_valid <= 1'b0;
    while (awaited_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d readings from %0d input words over %0d register settings.",
             readings_checked, words_accepted, settings_used + 1);
    $display("Covered beacon hits, tolerance edges, zero periods, period wrap and a long hold-off.");
    if (mismatches == 0) begin
      $display("capture_period_beacon_classifier_core verification clean");
    end else begin
      $display("capture_period_beacon_classifier_core verification failed");
    end
    $finish;
  end

endmodule
